// ===== rtl/slsfp_pkg.sv =====
// Shared types and constants for the sync/length/sum frame parser.
package slsfp_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND     = 8'hFE;
  localparam int unsigned HDR_LEN         = 6;
  localparam int unsigned MAX_FRAME_DEF   = 8192;
  localparam int unsigned CFG_W           = 14;
  localparam int unsigned CNT_W           = 14;
  localparam int unsigned OUT_CNT_W       = 13;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 14'd8192;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_SUM = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_LEN0 = 4'd1,
    PH_LEN1 = 4'd2,
    PH_LEN2 = 4'd3,
    PH_LEN3 = 4'd4,
    PH_CMD0 = 4'd5,
    PH_CMD1 = 4'd6,
    PH_DATA = 4'd7,
    PH_SUM0 = 4'd8,
    PH_SUM1 = 4'd9,
    PH_SUM2 = 4'd10,
    PH_SUM3 = 4'd11
  } phase_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [15:0]          command;
    logic [7:0]           payload_byte;
    logic [OUT_CNT_W-1:0] payload_count;
  } result_t;

endpackage

// ===== rtl/sync_length_sum_frame_parser.sv =====
// Top level of the sync/length/sum frame parser.
//
// Input channel: one received byte per transfer on in_rx_byte, accepted when
// in_valid is high and in_stall low. The parser hunts for FF FE, reads a
// 4-byte little-endian length, a 2-byte command, length-6 payload bytes and a
// 4-byte checksum (32-bit sum of payload bytes).
// Result channel: one result per payload byte (kind 0) and one at frame end
// (good or checksum mismatch), or one bad-length result on the last length
// byte; transferred when out_valid is high and out_stall low.
// Config: cfg_we writes cfg_wdata into the length limit (reset 8192); the
// effective limit is the smaller of that and MAX_FRAME. Write only when idle.
// Output: each result is registered on out_*, or in the skid entry if out_*
// stalls. Throughput: one byte per cycle while in_stall is low; each result
// is decoded combinationally between input transfer and result register.
// Reset (rst_n low, synchronous): parser returns to hunting, output and skid
// registers empty, limit back to 8192.
// Stall: a stalled result holds on out_*; one more result parks in the skid
// entry, then in_stall rises until the receiver takes a result.
module sync_length_sum_frame_parser import slsfp_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_result_kind,
  output logic [15:0]          out_command,
  output logic [7:0]           out_payload_byte,
  output logic [OUT_CNT_W-1:0] out_payload_count
);

  logic    in_fire;
  result_t res;
  result_t out_res;

  assign in_fire = in_valid && !in_stall;

  slsfp_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_rx_byte),
    .res       (res)
  );

  slsfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind   = out_res.kind;
  assign out_command       = out_res.command;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_count = out_res.payload_count;

endmodule

// ===== rtl/slsfp_parser.sv =====
// Frame parser state machine: sync hunt, header, payload sum and checksum check.
module slsfp_parser import slsfp_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  output result_t          res
);

  localparam logic [31:0] CAP = 32'(MAX_FRAME);
  localparam logic [31:0] MIN_LEN = 32'(HDR_LEN);

  phase_t           phase_r, phase_nxt;
  logic             prev_ff_r, prev_ff_nxt;
  logic [23:0]      len_r, len_nxt;
  logic [CNT_W-1:0] pay_len_r, pay_len_nxt;
  logic [15:0]      cmd_r, cmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [23:0]      rsum_r, rsum_nxt;
  logic [CFG_W-1:0] max_len_r;

  logic [31:0] limit;
  logic [31:0] full_len;
  logic [31:0] full_rsum;
  logic [CNT_W-1:0] cnt_inc;

  always_comb begin
    limit = (32'(max_len_r) > CAP) ? CAP : 32'(max_len_r);
  end

  assign full_len  = {in_byte, len_r};
  assign full_rsum = {in_byte, rsum_r};
  assign cnt_inc   = cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      prev_ff_r <= 1'b0;
      len_r     <= '0;
      pay_len_r <= '0;
      cmd_r     <= '0;
      cnt_r     <= '0;
      sum_r     <= '0;
      rsum_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      prev_ff_r <= prev_ff_nxt;
      len_r     <= len_nxt;
      pay_len_r <= pay_len_nxt;
      cmd_r     <= cmd_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      rsum_r    <= rsum_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    prev_ff_nxt = prev_ff_r;
    len_nxt     = len_r;
    pay_len_nxt = pay_len_r;
    cmd_nxt     = cmd_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    rsum_nxt    = rsum_r;
    res         = '0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (prev_ff_r && in_byte == SYNC_SECOND) begin
            prev_ff_nxt = 1'b0;
            len_nxt     = '0;
            phase_nxt   = PH_LEN0;
          end else begin
            prev_ff_nxt = (in_byte == SYNC_FIRST);
          end
        end
        PH_LEN0: begin
          len_nxt[7:0] = in_byte;
          phase_nxt    = PH_LEN1;
        end
        PH_LEN1: begin
          len_nxt[15:8] = in_byte;
          phase_nxt     = PH_LEN2;
        end
        PH_LEN2: begin
          len_nxt[23:16] = in_byte;
          phase_nxt      = PH_LEN3;
        end
        PH_LEN3: begin
          if (full_len < MIN_LEN || full_len > limit) begin
            phase_nxt = PH_HUNT;
            res.valid = 1'b1;
            res.kind  = KIND_BAD_LEN;
          end else begin
            pay_len_nxt = full_len[CNT_W-1:0] - CNT_W'(HDR_LEN);
            phase_nxt   = PH_CMD0;
          end
        end
        PH_CMD0: begin
          cmd_nxt[7:0] = in_byte;
          phase_nxt    = PH_CMD1;
        end
        PH_CMD1: begin
          cmd_nxt[15:8] = in_byte;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          rsum_nxt      = '0;
          phase_nxt     = (pay_len_r == '0) ? PH_SUM0 : PH_DATA;
        end
        PH_DATA: begin
          sum_nxt = sum_r + 32'(in_byte);
          cnt_nxt = cnt_inc;
          if (cnt_inc >= pay_len_r) begin
            phase_nxt = PH_SUM0;
          end
          res.valid         = 1'b1;
          res.kind          = KIND_DATA;
          res.command       = cmd_r;
          res.payload_byte  = in_byte;
          res.payload_count = cnt_r[OUT_CNT_W-1:0];
        end
        PH_SUM0: begin
          rsum_nxt[7:0] = in_byte;
          phase_nxt     = PH_SUM1;
        end
        PH_SUM1: begin
          rsum_nxt[15:8] = in_byte;
          phase_nxt      = PH_SUM2;
        end
        PH_SUM2: begin
          rsum_nxt[23:16] = in_byte;
          phase_nxt       = PH_SUM3;
        end
        PH_SUM3: begin
          phase_nxt         = PH_HUNT;
          prev_ff_nxt       = 1'b0;
          res.valid         = 1'b1;
          res.kind          = (full_rsum == sum_r) ? KIND_GOOD : KIND_BAD_SUM;
          res.command       = cmd_r;
          res.payload_count = cnt_r[OUT_CNT_W-1:0];
        end
        default: begin
          phase_nxt   = PH_HUNT;
          prev_ff_nxt = (in_byte == SYNC_FIRST);
        end
      endcase
    end
  end

  a_ff_only_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HUNT) |-> !prev_ff_r)
    else $error("sync arm flag set outside hunt");

  a_data_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < pay_len_r))
    else $error("payload counter past payload length");

  a_result_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_fire)
    else $error("result raised without an input transfer");

endmodule

// ===== rtl/slsfp_out_buf.sv =====
// Result register with one skid entry between parser and result channel.
module slsfp_out_buf import slsfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  result_t res,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && out_stall) begin
      // hold the output, park a new result
      if (res.valid) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = res.valid;
      out_data_nxt  = res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_no_result_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res.valid)
    else $error("result arrived while skid entry full");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the frame parser: byte streams in, results checked.
`timescale 1ns / 100ps

module testbench import slsfp_pkg::*;;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    kind_t                kind;
    logic [15:0]          command;
    logic [7:0]           payload_byte;
    logic [OUT_CNT_W-1:0] payload_count;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_result_kind;
  logic [15:0]          out_command;
  logic [7:0]           out_payload_byte;
  logic [OUT_CNT_W-1:0] out_payload_count;

  // parse predictor state
  phase_t               parse_phase = PH_HUNT;
  logic                 parse_after_ff = 1'b0;
  logic [31:0]          parse_length = '0;
  logic [15:0]          parse_command = '0;
  logic [CNT_W-1:0]     parse_count = '0;
  logic [31:0]          parse_sum = '0;
  logic [31:0]          parse_check = '0;
  logic [CFG_W-1:0]     length_limit_reg = MAX_LEN_RESET;

  frame_result_t        pending_results[$];
  int unsigned          cycle_count = 0;
  int unsigned          error_count = 0;
  int unsigned          bytes_sent = 0;
  int unsigned          bytes_accepted = 0;
  int unsigned          kind_count[4] = '{0, 0, 0, 0};
  bit                   tx_idling = 1'b0;
  bit                   rx_idling = 1'b0;
  int unsigned          stall_hold_cycles = 0;

  sync_length_sum_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_command      (out_command),
    .out_payload_byte (out_payload_byte),
    .out_payload_count(out_payload_count)
  );

  always #4 clk = ~clk;

  function automatic int unsigned active_limit();
    return (length_limit_reg > MAX_FRAME_DEF) ? MAX_FRAME_DEF : int'(length_limit_reg);
  endfunction

  function automatic bit length_ok(input logic [31:0] len);
    return (len >= HDR_LEN) && (len <= active_limit());
  endfunction

  function automatic void queue_result(input kind_t k, input logic [15:0] c,
                                       input logic [7:0] b, input logic [OUT_CNT_W-1:0] n);
    frame_result_t r;
    r.kind = k;
    r.command = c;
    r.payload_byte = b;
    r.payload_count = n;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    int k;
    logic [CNT_W-1:0] idx;
    case (parse_phase)
      PH_HUNT: begin
        if (parse_after_ff && b == SYNC_SECOND) begin
          parse_after_ff = 1'b0;
          parse_length = '0;
          parse_phase = PH_LEN0;
        end else begin
          parse_after_ff = (b == SYNC_FIRST);
        end
      end
      PH_LEN0, PH_LEN1, PH_LEN2: begin
        k = int'(parse_phase) - int'(PH_LEN0);
        parse_length[8*k +: 8] = b;
        parse_phase = phase_t'(parse_phase + 4'd1);
      end
      PH_LEN3: begin
        parse_length[31:24] = b;
        if (!length_ok(parse_length)) begin
          parse_phase = PH_HUNT;
          queue_result(KIND_BAD_LEN, 16'h0000, 8'h00, '0);
        end else begin
          parse_phase = PH_CMD0;
        end
      end
      PH_CMD0: begin
        parse_command = {8'h00, b};
        parse_phase = PH_CMD1;
      end
      PH_CMD1: begin
        parse_command[15:8] = b;
        parse_count = '0;
        parse_sum = '0;
        parse_check = '0;
        parse_phase = (parse_length == HDR_LEN) ? PH_SUM0 : PH_DATA;
      end
      PH_DATA: begin
        idx = parse_count;
        parse_sum = parse_sum + {24'h0, b};
        parse_count = parse_count + 1'b1;
        if (32'(parse_count) >= parse_length - HDR_LEN) parse_phase = PH_SUM0;
        queue_result(KIND_DATA, parse_command, b, idx[OUT_CNT_W-1:0]);
      end
      PH_SUM0, PH_SUM1, PH_SUM2: begin
        k = int'(parse_phase) - int'(PH_SUM0);
        parse_check[8*k +: 8] = b;
        parse_phase = phase_t'(parse_phase + 4'd1);
      end
      PH_SUM3: begin
        parse_check[31:24] = b;
        parse_phase = PH_HUNT;
        parse_after_ff = 1'b0;
        queue_result((parse_check == parse_sum) ? KIND_GOOD : KIND_BAD_SUM,
                     parse_command, 8'h00, parse_count[OUT_CNT_W-1:0]);
      end
      default: begin
        parse_phase = PH_HUNT;
        parse_after_ff = (b == SYNC_FIRST);
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall) begin
      parse_rx_byte(in_rx_byte);
      bytes_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind=%0d cmd=%h byte=%h count=%0d",
                 $time, out_result_kind, out_command, out_payload_byte, out_payload_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind !== want.kind || out_command !== want.command ||
            out_payload_byte !== want.payload_byte ||
            out_payload_count !== want.payload_count) begin
          $display("%0t: mismatch, expected kind=%0d cmd=%h byte=%h count=%0d,",
                   $time, want.kind, want.command, want.payload_byte, want.payload_count);
          $display("    got kind=%0d cmd=%h byte=%h count=%0d",
                   out_result_kind, out_command, out_payload_byte, out_payload_count);
          error_count++;
        end
        kind_count[want.kind]++;
      end
    end
  end

  function automatic int idle_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (stall_hold_cycles != 0) begin
        n = stall_hold_cycles;
        stall_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (idle_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom);
      repeat (idle_gap()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // hold input low until every expected result has been transferred
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length_limit(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    length_limit_reg = value;
    cfg_we <= 1'b0;
  endtask

  // fill < 0 gives random payload bytes, else every payload byte is fill
  task automatic send_frame(input logic [31:0] len, input logic [15:0] cmd,
                            input logic [31:0] sum_delta, input int fill);
    int i;
    logic [7:0] b;
    logic [31:0] sum;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
    if (!length_ok(len)) return;
    send_byte(cmd[7:0]);
    send_byte(cmd[15:8]);
    sum = '0;
    for (i = 0; i < len - HDR_LEN; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      sum = sum + {24'h0, b};
      send_byte(b);
    end
    sum = sum + sum_delta;
    for (i = 0; i < 4; i++) send_byte(sum[8*i +: 8]);
  endtask

  task automatic send_noise(output int count);
    int i;
    count = $urandom_range(1, 8);
    for (i = 0; i < count; i++)
      send_byte(($urandom_range(0, 2) == 0) ? SYNC_FIRST : 8'($urandom));
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned room;
    room = active_limit() - HDR_LEN;
    if ($urandom_range(0, 19) == 0)
      return HDR_LEN + $urandom_range(0, (room < 200) ? room : 200);
    return HDR_LEN + $urandom_range(0, (room < 24) ? room : 24);
  endfunction

  task automatic test_lengths();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    send_frame(32'd0, 16'h1234, 32'h0, -1);
    send_frame(32'd5, 16'h1234, 32'h0, -1);
    send_frame(32'd6, 16'h0000, 32'h0, -1);
    send_frame(32'd7, 16'hFFFF, 32'h0, 8'hFF);
    send_frame(32'd8193, 16'h4321, 32'h0, -1);
    send_frame(32'hFFFF_FFFF, 16'h4321, 32'h0, -1);
    send_frame(32'h0100_0006, 16'h4321, 32'h0, -1);
    send_frame(32'd20, 16'hA5C3, 32'h0, -1);
  endtask

  task automatic test_checksums();
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    send_frame(32'd16, 16'h00FF, 32'h0, 8'hFF);
    send_frame(32'd16, 16'hFF00, 32'h0000_0001, -1);
    send_frame(32'd16, 16'h5A5A, 32'h0000_0100, -1);
    send_frame(32'd16, 16'hA5A5, 32'h0001_0000, -1);
    send_frame(32'd16, 16'h0F0F, 32'h0100_0000, -1);
    send_frame(32'd12, 16'hF0F0, 32'h0, 8'h00);
    send_frame(32'd6, 16'h7777, 32'hFFFF_FFFF, -1);
  endtask

  task automatic test_sync_hunt();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_frame(32'd9, 16'h1111, 32'h0, -1);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_SECOND);
    send_frame(32'd8, 16'h2222, 32'h0, -1);
    // last checksum byte is FF; the FE after it must not complete a sync word
    send_frame(32'd7, 16'h3333, 32'hFF00_0000, 8'h01);
    send_byte(SYNC_SECOND);
    send_byte(8'h06);
    send_frame(32'd3, 16'h4444, 32'h0, -1);
    send_frame(32'd10, 16'h5555, 32'h0, -1);
  endtask

  task automatic test_length_limits();
    write_length_limit(14'd0);
    send_frame(32'd6, 16'h6001, 32'h0, -1);
    write_length_limit(14'd5);
    send_frame(32'd5, 16'h6002, 32'h0, -1);
    send_frame(32'd6, 16'h6003, 32'h0, -1);
    write_length_limit(14'd6);
    send_frame(32'd6, 16'h6004, 32'h0, -1);
    send_frame(32'd7, 16'h6005, 32'h0, -1);
    write_length_limit(14'd7);
    send_frame(32'd7, 16'h6006, 32'h0, -1);
    send_frame(32'd8, 16'h6007, 32'h0, -1);
    write_length_limit(14'd16383);
    send_frame(32'd8193, 16'h6008, 32'h0, -1);
    send_frame(32'd300, 16'h6009, 32'h0, -1);
  endtask

  task automatic test_frame_at_limit();
    write_length_limit(14'd400);
    send_frame(32'd400, 16'hC3A5, 32'h0, -1);
    send_frame(32'd401, 16'hC3A6, 32'h0, -1);
  endtask

  task automatic test_backpressure();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    stall_hold_cycles = 80;
    send_frame(32'd66, 16'hBEEF, 32'h0, -1);
    send_frame(32'd20, 16'hCAFE, 32'h0, -1);
    drain_results();
    send_frame(32'd30, 16'hD00D, 32'h0, -1);
    rx_idling = 1'b1;
    send_frame(32'd30, 16'hD00E, 32'h5, -1);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] phase_limit;
    logic [31:0] len;
    int p, start, ignored, n;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    for (p = 0; p < 4; p++) begin
      case (p)
        0: phase_limit = 14'd16383;
        1: phase_limit = 14'd300;
        2: phase_limit = 14'd12;
        default: phase_limit = 14'd8192;
      endcase
      write_length_limit(phase_limit);
      start = bytes_sent;
      ignored = 0;
      while (bytes_sent - start - ignored < 170) begin
        if ($urandom_range(0, 39) == 0) tx_idling = ~tx_idling;
        if ($urandom_range(0, 39) == 0) rx_idling = ~rx_idling;
        case ($urandom_range(0, 99)) inside
          [0:69]:
            send_frame(pick_length(), 16'($urandom), 32'h0, -1);
          [70:79]:
            send_frame(pick_length(), 16'($urandom),
                       32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)), -1);
          [80:86]: begin
            case ($urandom_range(0, 2))
              0: len = $urandom_range(0, 5);
              1: len = active_limit() + 1 + $urandom_range(0, 50);
              default: len = $urandom | 32'h8000_0000;
            endcase
            send_frame(len, 16'($urandom), 32'h0, -1);
          end
          [87:93]: begin
            send_noise(n);
            ignored += n;
          end
          default: begin
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lengths();
    test_checksums();
    test_sync_hunt();
    test_length_limits();
    test_frame_at_limit();
    test_backpressure();
    test_random();
    drain_results();
    $display("Covered %0d accepted bytes and %0d results:",
             bytes_accepted, kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3]);
    $display("  %0d payload, %0d good, %0d bad checksum, %0d bad length",
             kind_count[KIND_DATA], kind_count[KIND_GOOD], kind_count[KIND_BAD_SUM],
             kind_count[KIND_BAD_LEN]);
    $display("Length limits 0 through 16383, a frame at the limit, long output stall");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
